FILE: rtl/trimmed_mean_angle_rate_top_defines.svh
// assertion macros for the trimmed mean angle rate block
// used by the port checker; no other dependencies
`ifndef TRIMMED_MEAN_ANGLE_RATE_TOP_DEFINES_SVH
`define TRIMMED_MEAN_ANGLE_RATE_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define TMA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define TMA_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tma_pkg.sv
// shared widths, constants and payload types for the trimmed mean angle rate block
// no dependencies
package tma_pkg;

    localparam int ANGLE_W        = 32;
    localparam int RATE_W         = 48;
    localparam int SUM_W          = 36;
    localparam int CFG_W          = 10;
    localparam int WINDOW_DEFAULT = 10;
    // low part of the magnitude handled in the second divider step
    localparam int DIV_LO_W       = 17;

    localparam logic [CFG_W-1:0] RATE_RESET = CFG_W'(10);

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } tma_in_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] pitch_rate;
        logic signed [RATE_W-1:0] yaw_rate;
    } tma_out_t;

    // trimmed mean as sign and magnitude
    typedef struct packed {
        logic               neg;
        logic [ANGLE_W-1:0] mag;
    } tma_quot_t;

endpackage

FILE: rtl/tma_div.sv
// two-stage divide of the trimmed window sum by WINDOW-2, truncated toward zero
// uses tma_pkg; constant reciprocal multiply on a high and a low slice
module tma_div #(
    parameter int WINDOW = tma_pkg::WINDOW_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [tma_pkg::SUM_W-1:0]     t_in,
    output tma_pkg::tma_quot_t                   quot_out
);
    import tma_pkg::*;

    localparam int DIV   = WINDOW - 2;
    localparam int MAG_W = SUM_W - 1;
    localparam int LO_W  = DIV_LO_W;
    localparam int HI_W  = MAG_W - LO_W;
    localparam int REM_W = $clog2(WINDOW);
    localparam int V_W   = REM_W + LO_W;
    // shift chosen so floor(x * m >> s) is exact for every x of the slice
    localparam int S1    = HI_W + REM_W;
    localparam int S2    = V_W + REM_W;
    localparam logic [S1:0] M1 = (S1 + 1)'(((64'd1 << S1) + 64'(DIV) - 64'd1) / 64'(DIV));
    localparam logic [S2:0] M2 = (S2 + 1)'(((64'd1 << S2) + 64'(DIV) - 64'd1) / 64'(DIV));
    localparam logic [HI_W-1:0] DIV_H = HI_W'(DIV);

    logic [SUM_W-1:0]     mag_full;
    logic [MAG_W-1:0]     mag;
    logic [HI_W-1:0]      hi;
    logic [HI_W+S1:0]     prod1;
    logic [HI_W-1:0]      q_hi;
    logic [HI_W-1:0]      rem_hi;

    logic                 neg_reg;
    logic [HI_W-1:0]      q_hi_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [LO_W-1:0]      lo_reg;

    logic [V_W-1:0]       v;
    logic [V_W+S2:0]      prod2;
    logic [LO_W-1:0]      q_lo;
    logic [MAG_W-1:0]     q_full;
    tma_quot_t            quot_reg;

    // first step: magnitude, quotient and remainder of the high slice
    always_comb begin
        mag_full = t_in[SUM_W-1] ? (SUM_W'(0) - t_in) : t_in;
        mag      = mag_full[MAG_W-1:0];
        hi       = mag[MAG_W-1:LO_W];
        prod1    = hi * M1;
        q_hi     = prod1[S1 +: HI_W];
        rem_hi   = hi - HI_W'(q_hi * DIV_H);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg  <= t_in[SUM_W-1];
            q_hi_reg <= q_hi;
            rem_reg  <= rem_hi[REM_W-1:0];
            lo_reg   <= mag[LO_W-1:0];
        end
    end

    // second step: remainder carried into the low slice
    always_comb begin
        v      = {rem_reg, lo_reg};
        prod2  = v * M2;
        q_lo   = prod2[S2 +: LO_W];
        q_full = {q_hi_reg, q_lo};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg.neg <= neg_reg;
            quot_reg.mag <= q_full[ANGLE_W-1:0];
        end
    end

    assign quot_out = quot_reg;

endmodule

FILE: rtl/trimmed_mean_angle_rate_top.sv
// trimmed mean angle rate: one input transaction per cycle; a result leaves through the
// snapshot, trim, two divide steps, difference and rate multiply registers after the
// transaction that closes a window. The input stalls only when a window closes while the
// snapshot stage is full and the output register is held by m_ready low.
// Reset (aresetn low, synchronous) empties the window and the pipeline, zeroes the
// previous means and loads rate_reg with 10.
module trimmed_mean_angle_rate_top #(
    parameter int WINDOW = tma_pkg::WINDOW_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tma_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tma_pkg::tma_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tma_pkg::tma_out_t             m_data
);
    import tma_pkg::*;

    localparam int CNT_W = $clog2(WINDOW);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW - 1);
    localparam int DIFF_W = ANGLE_W + 1;
    localparam int PROD_W = DIFF_W + CFG_W + 1;

    logic [CFG_W-1:0] rate_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic signed [SUM_W-1:0]   pitch_sum_reg, yaw_sum_reg;
    logic signed [ANGLE_W-1:0] pitch_max_reg, pitch_min_reg, yaw_max_reg, yaw_min_reg;
    logic signed [SUM_W-1:0]   pitch_sum_next, yaw_sum_next;
    logic signed [ANGLE_W-1:0] pitch_max_next, pitch_min_next, yaw_max_next, yaw_min_next;

    logic signed [ANGLE_W-1:0] pa, ya;
    logic first, last, accept, adv;

    // closed window waiting for the trim stage
    logic                      snap_v_reg;
    logic signed [SUM_W-1:0]   snap_psum_reg, snap_ysum_reg;
    logic signed [ANGLE_W-1:0] snap_pmax_reg, snap_pmin_reg, snap_ymax_reg, snap_ymin_reg;

    logic                      p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, out_v_reg;
    logic signed [SUM_W-1:0]   ptrim_reg, ytrim_reg;
    tma_quot_t                 pquot, yquot;
    logic signed [ANGLE_W-1:0] pmean, ymean;
    logic signed [ANGLE_W-1:0] pitch_mean_prev_reg, yaw_mean_prev_reg;
    logic signed [DIFF_W-1:0]  pdiff_reg, ydiff_reg;
    logic signed [PROD_W-1:0]  pprod, yprod;
    tma_out_t                  out_reg;

    assign pa     = s_data.pitch_angle;
    assign ya     = s_data.yaw_angle;
    assign first  = (cnt_reg == '0);
    assign last   = (cnt_reg == LAST_CNT);
    assign adv    = !out_v_reg || m_ready;
    assign s_ready = !last || !snap_v_reg || adv;
    assign accept = s_valid && s_ready;

    // running sum and extremes; the first sample of a window reloads them
    always_comb begin
        if (first) begin
            pitch_sum_next = SUM_W'(pa);
            yaw_sum_next   = SUM_W'(ya);
            pitch_max_next = pa;
            pitch_min_next = pa;
            yaw_max_next   = ya;
            yaw_min_next   = ya;
        end else begin
            pitch_sum_next = pitch_sum_reg + SUM_W'(pa);
            yaw_sum_next   = yaw_sum_reg + SUM_W'(ya);
            pitch_max_next = (pa > pitch_max_reg) ? pa : pitch_max_reg;
            pitch_min_next = (pa < pitch_min_reg) ? pa : pitch_min_reg;
            yaw_max_next   = (ya > yaw_max_reg) ? ya : yaw_max_reg;
            yaw_min_next   = (ya < yaw_min_reg) ? ya : yaw_min_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
        end else if (cfg_we) begin
            rate_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= last ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pitch_sum_reg <= pitch_sum_next;
            yaw_sum_reg   <= yaw_sum_next;
            pitch_max_reg <= pitch_max_next;
            pitch_min_reg <= pitch_min_next;
            yaw_max_reg   <= yaw_max_next;
            yaw_min_reg   <= yaw_min_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_v_reg <= 1'b0;
        end else if (accept && last) begin
            snap_v_reg <= 1'b1;
        end else if (adv) begin
            snap_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && last) begin
            snap_psum_reg <= pitch_sum_next;
            snap_ysum_reg <= yaw_sum_next;
            snap_pmax_reg <= pitch_max_next;
            snap_pmin_reg <= pitch_min_next;
            snap_ymax_reg <= yaw_max_next;
            snap_ymin_reg <= yaw_min_next;
        end
    end

    // pipeline valids move together while the output can take a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            p1_v_reg  <= snap_v_reg;
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            p4_v_reg  <= p3_v_reg;
            out_v_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ptrim_reg <= snap_psum_reg - SUM_W'(snap_pmax_reg) - SUM_W'(snap_pmin_reg);
            ytrim_reg <= snap_ysum_reg - SUM_W'(snap_ymax_reg) - SUM_W'(snap_ymin_reg);
        end
    end

    tma_div #(
        .WINDOW (WINDOW)
    ) u_pitch_div (
        .aclk     (aclk),
        .en       (adv),
        .t_in     (ptrim_reg),
        .quot_out (pquot)
    );

    tma_div #(
        .WINDOW (WINDOW)
    ) u_yaw_div (
        .aclk     (aclk),
        .en       (adv),
        .t_in     (ytrim_reg),
        .quot_out (yquot)
    );

    always_comb begin
        pmean = pquot.neg ? (ANGLE_W'(0) - $signed(pquot.mag)) : $signed(pquot.mag);
        ymean = yquot.neg ? (ANGLE_W'(0) - $signed(yquot.mag)) : $signed(yquot.mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_mean_prev_reg <= '0;
            yaw_mean_prev_reg   <= '0;
        end else if (adv && p3_v_reg) begin
            pitch_mean_prev_reg <= pmean;
            yaw_mean_prev_reg   <= ymean;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pdiff_reg <= DIFF_W'(pmean) - DIFF_W'(pitch_mean_prev_reg);
            ydiff_reg <= DIFF_W'(ymean) - DIFF_W'(yaw_mean_prev_reg);
        end
    end

    // the product stays inside 44 bits, so the 48-bit clamp reduces to sign extension
    always_comb begin
        pprod = PROD_W'(pdiff_reg) * $signed({1'b0, rate_reg});
        yprod = PROD_W'(ydiff_reg) * $signed({1'b0, rate_reg});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.pitch_rate <= RATE_W'(pprod);
            out_reg.yaw_rate   <= RATE_W'(yprod);
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/tma_chk.sv
// port-level checker for the trimmed mean angle rate block, bound to the top level
// uses tma_pkg and the assertion macros header
`include "trimmed_mean_angle_rate_top_defines.svh"

module tma_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input tma_pkg::tma_in_t              s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input tma_pkg::tma_out_t             m_data
);
    import tma_pkg::*;

    logic held;
    logic s_wait;

    assign held   = m_valid && !m_ready;
    assign s_wait = s_valid && !s_ready;

    // a stalled result transaction keeps its payload
    `TMA_ASSERT_NEXT(a_out_hold, aclk, aresetn, held, m_valid && $stable(m_data), "result changed while stalled")

    // a waiting input transaction keeps its payload
    `TMA_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_wait, s_valid && $stable(s_data), "input changed while waiting")

    // with nothing waiting at the output the input side is never stalled
    `TMA_ASSERT_SAME(a_ready_free, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output")

    // reset empties the output register
    `TMA_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid, "result present after reset")

endmodule

bind trimmed_mean_angle_rate_top tma_chk u_tma_chk (.*);
